FILE: hdl/gllw_pkg.sv
// ----------------------------------------------------------------------------
// gllw_pkg
// Types, constants and codes shared by the glyph line wrap layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package gllw_pkg;

   localparam int MAX_WORD_GLYPHS_DEF  = 31;
   localparam int GLYPH_INDEX_BITS_DEF = 12;
   localparam int BUF_DEPTH_LIMIT      = 31;

   localparam logic [22:0] WRAP_NO_LIMIT = 23'h7FFFFF;
   localparam logic signed [23:0] S24_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] S24_MIN = -24'sh800000;

   // Width of the shared adder operands and its raw sum.
   localparam int ALU_IN_BITS  = 26;
   localparam int ALU_OUT_BITS = 27;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 23;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BREAK_MODE   = 2'd0,
      CSR_WRAP_WIDTH   = 2'd1,
      CSR_LINE_HEIGHT  = 2'd2,
      CSR_LINE_SPACING = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BREAK_NONE   = 2'd0,
      BREAK_CHAR   = 2'd1,
      BREAK_WORD   = 2'd2,
      BREAK_UNUSED = 2'd3
   } break_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEST_LEFT,
      ST_TEST_ADV,
      ST_LINE,
      ST_FLUSH_X,
      ST_FLUSH_Y,
      ST_FLUSH_ADV,
      ST_FLUSH_EMIT,
      ST_FLUSH_WAIT,
      ST_POS_X,
      ST_POS_Y1,
      ST_POS_Y2,
      ST_PEN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [15:0] inset_left;
      logic signed [15:0] inset_top;
      logic [15:0]        advance;
      logic               is_space;
      logic               is_final;
   } req_type;

   typedef struct packed {
      logic [11:0]        glyph_number;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic               is_reposition;
      logic               word_overflow;
      logic               last_of_run;
   } rsp_type;

   // One buffered glyph of the current word.
   typedef struct packed {
      logic [11:0]        num;
      logic signed [15:0] left;
      logic [15:0]        adv;
      logic signed [23:0] y;
   } entry_type;

endpackage

`default_nettype wire

FILE: hdl/gllw_ram.sv
// ----------------------------------------------------------------------------
// gllw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gllw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/gllw_alu.sv
// ----------------------------------------------------------------------------
// gllw_alu
// Shared add/subtract unit with a raw sum and a 24-bit saturated sum.
// ----------------------------------------------------------------------------
`default_nettype none

module gllw_alu
   import gllw_pkg::*;
(
   input  wire logic signed [ALU_IN_BITS-1:0]  op_a,
   input  wire logic signed [ALU_IN_BITS-1:0]  op_b,
   input  wire logic                           sub,
   output logic signed      [ALU_OUT_BITS-1:0] sum_raw,
   output logic signed      [23:0]             sum_sat
);

   logic signed [ALU_OUT_BITS-1:0] a_ext;
   logic signed [ALU_OUT_BITS-1:0] b_ext;

   always_comb begin
      a_ext   = ALU_OUT_BITS'(op_a);
      b_ext   = ALU_OUT_BITS'(op_b);
      sum_raw = sub ? (a_ext - b_ext) : (a_ext + b_ext);
      // clamp to the 24-bit signed range
      if (sum_raw > ALU_OUT_BITS'(S24_MAX)) begin
         sum_sat = S24_MAX;
      end else if (sum_raw < ALU_OUT_BITS'(S24_MIN)) begin
         sum_sat = S24_MIN;
      end else begin
         sum_sat = sum_raw[23:0];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/glyph_line_wrap_layout.sv
// ----------------------------------------------------------------------------
// glyph_line_wrap_layout
// Greedy line wrap layout: glyph metrics in, pen positions out.
// ----------------------------------------------------------------------------
// Each glyph transaction yields its pen position in signed Q15.8 pixels. In
// word mode a space or final glyph that crosses the wrap width first emits
// repositions for the buffered word, then the glyph itself; last_of_run marks
// the final result of a glyph. One sequencer drives one shared saturating
// adder: a glyph runs the width test, a new-line step on a wrap, a pass per
// flushed glyph, then position, pen and emit, held by any output stall. The
// block is stalled while a glyph is in work. The word buffer is a RAM with
// registered read; it needs no clearing after reset. Configuration writes are
// always accepted and must be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_line_wrap_layout
   import gllw_pkg::*;
#(
   parameter int MAX_WORD_GLYPHS  = MAX_WORD_GLYPHS_DEF,
   parameter int GLYPH_INDEX_BITS = GLYPH_INDEX_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int BUF_DEPTH = (MAX_WORD_GLYPHS > BUF_DEPTH_LIMIT) ?
                              BUF_DEPTH_LIMIT : MAX_WORD_GLYPHS;
   localparam int WC_BITS   = $clog2(BUF_DEPTH + 1);
   localparam int IDX_BITS  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   // configuration
   logic [1:0]  break_mode_ff;
   logic [22:0] wrap_width_ff;
   logic [15:0] line_height_ff;
   logic [15:0] line_spacing_ff;
   logic [16:0] line_step;

   // layout state
   state_type                     state_ff, state_in;
   logic signed [23:0]            pen_x_ff;
   logic signed [23:0]            line_y_ff;
   logic [GLYPH_INDEX_BITS-1:0]   glyph_counter_ff;
   logic [WC_BITS-1:0]            word_count_ff;
   logic                          word_ovf_ff;
   logic [WC_BITS-1:0]            idx_ff;

   // per-glyph work registers
   req_type                       glyph_ff;
   logic [11:0]                   num_ff;
   logic signed [ALU_IN_BITS-1:0] tmp_ff;
   logic signed [23:0]            px_ff;
   logic signed [23:0]            py_ff;
   logic signed [23:0]            fx_ff;
   logic signed [23:0]            fy_ff;
   logic                          push_ff;
   logic                          word_end_ff;
   logic                          flush_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    out_free;
   logic    emit_now;

   // shared unit
   logic signed [ALU_IN_BITS-1:0]  alu_a;
   logic signed [ALU_IN_BITS-1:0]  alu_b;
   logic                           alu_sub;
   logic signed [ALU_OUT_BITS-1:0] alu_raw;
   logic signed [23:0]             alu_sat;

   // word buffer
   logic                    ram_wr_en;
   logic [IDX_BITS-1:0]     ram_wr_addr;
   entry_type               ram_wr_entry;
   logic [$bits(entry_type)-1:0] ram_rd_data;
   entry_type               ent;

   logic                    exceeds;
   logic                    is_break;
   logic                    wrap_now;
   logic                    word_mode;
   logic                    word_full;
   logic [WC_BITS-1:0]      idx_next;
   logic signed [ALU_OUT_BITS-1:0] wrap_ext;

   assign line_step = 17'(line_height_ff) + 17'(line_spacing_ff);
   assign ent       = entry_type'(ram_rd_data);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_now  = out_free && ((state_ff == ST_FLUSH_EMIT) || (state_ff == ST_EMIT));
   assign idx_next  = idx_ff + WC_BITS'(1);
   assign wrap_ext  = ALU_OUT_BITS'(wrap_width_ff);
   assign exceeds   = (wrap_width_ff != WRAP_NO_LIMIT) && (alu_raw >= wrap_ext);
   assign is_break  = glyph_ff.is_space || glyph_ff.is_final;
   assign word_mode = (break_mode_ff == BREAK_WORD);
   assign word_full = (word_count_ff >= WC_BITS'(BUF_DEPTH));

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   gllw_alu u_alu (
      .op_a    (alu_a),
      .op_b    (alu_b),
      .sub     (alu_sub),
      .sum_raw (alu_raw),
      .sum_sat (alu_sat)
   );

   gllw_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (BUF_DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_addr (idx_ff[IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         break_mode_ff   <= BREAK_NONE;
         wrap_width_ff   <= WRAP_NO_LIMIT;
         line_height_ff  <= '0;
         line_spacing_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BREAK_MODE:   break_mode_ff   <= csr_data[1:0];
            CSR_WRAP_WIDTH:   wrap_width_ff   <= csr_data;
            CSR_LINE_HEIGHT:  line_height_ff  <= csr_data[15:0];
            CSR_LINE_SPACING: line_spacing_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // wrap decision at the end of the width test
   always_comb begin
      wrap_now = 1'b0;
      case (break_mode_type'(break_mode_ff))
         BREAK_WORD: wrap_now = is_break && exceeds;
         BREAK_CHAR: wrap_now = exceeds;
         default:    wrap_now = 1'b0;
      endcase
   end

   // sequencer: next state, shared unit operands, buffer writes
   always_comb begin
      state_in     = state_ff;
      alu_a        = '0;
      alu_b        = '0;
      alu_sub      = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[IDX_BITS-1:0];
      ram_wr_entry = ent;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_TEST_LEFT;
            end
         end
         ST_TEST_LEFT: begin
            alu_a    = ALU_IN_BITS'(pen_x_ff);
            alu_b    = ALU_IN_BITS'(glyph_ff.inset_left);
            state_in = ST_TEST_ADV;
         end
         ST_TEST_ADV: begin
            alu_a    = tmp_ff;
            alu_b    = ALU_IN_BITS'(glyph_ff.advance);
            state_in = wrap_now ? ST_LINE : ST_POS_X;
         end
         ST_LINE: begin
            alu_a = ALU_IN_BITS'(line_y_ff);
            alu_b = ALU_IN_BITS'(line_step);
            if (flush_ff && (word_count_ff != '0)) begin
               state_in = ST_FLUSH_X;
            end else begin
               state_in = ST_POS_X;
            end
         end
         ST_FLUSH_X: begin
            alu_a    = ALU_IN_BITS'(pen_x_ff);
            alu_b    = ALU_IN_BITS'(ent.left);
            state_in = ST_FLUSH_Y;
         end
         ST_FLUSH_Y: begin
            alu_a          = ALU_IN_BITS'(ent.y);
            alu_b          = ALU_IN_BITS'(line_step);
            ram_wr_en      = 1'b1;
            ram_wr_entry.y = alu_sat;
            state_in       = ST_FLUSH_ADV;
         end
         ST_FLUSH_ADV: begin
            alu_a    = ALU_IN_BITS'(fx_ff);
            alu_b    = ALU_IN_BITS'(ent.adv);
            state_in = ST_FLUSH_EMIT;
         end
         ST_FLUSH_EMIT: begin
            if (out_free) begin
               state_in = (idx_next == word_count_ff) ? ST_POS_X : ST_FLUSH_WAIT;
            end
         end
         ST_FLUSH_WAIT: begin
            state_in = ST_FLUSH_X;
         end
         ST_POS_X: begin
            alu_a    = ALU_IN_BITS'(pen_x_ff);
            alu_b    = ALU_IN_BITS'(glyph_ff.inset_left);
            state_in = ST_POS_Y1;
         end
         ST_POS_Y1: begin
            alu_a    = ALU_IN_BITS'(line_y_ff);
            alu_b    = ALU_IN_BITS'(line_height_ff);
            state_in = ST_POS_Y2;
         end
         ST_POS_Y2: begin
            alu_a    = tmp_ff;
            alu_b    = ALU_IN_BITS'(glyph_ff.inset_top);
            alu_sub  = 1'b1;
            state_in = ST_PEN;
         end
         ST_PEN: begin
            alu_a             = ALU_IN_BITS'(px_ff);
            alu_b             = ALU_IN_BITS'(glyph_ff.advance);
            ram_wr_en         = push_ff;
            ram_wr_addr       = word_count_ff[IDX_BITS-1:0];
            ram_wr_entry.num  = num_ff;
            ram_wr_entry.left = glyph_ff.inset_left;
            ram_wr_entry.adv  = glyph_ff.advance;
            ram_wr_entry.y    = py_ff;
            state_in          = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // layout state and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff         <= '0;
         line_y_ff        <= '0;
         glyph_counter_ff <= '0;
         word_count_ff    <= '0;
         word_ovf_ff      <= 1'b0;
         idx_ff           <= '0;
         push_ff          <= 1'b0;
         word_end_ff      <= 1'b0;
         flush_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // raise on a new result, drop once it is taken
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  glyph_ff <= req_data;
                  num_ff   <= 12'(glyph_counter_ff);
                  idx_ff   <= '0;
               end
            end
            ST_TEST_LEFT: begin
               tmp_ff <= ALU_IN_BITS'(alu_raw);
            end
            ST_TEST_ADV: begin
               push_ff     <= word_mode && !is_break && !word_full;
               word_end_ff <= word_mode && is_break;
               flush_ff    <= word_mode && is_break && exceeds;
               if (word_mode && !is_break && word_full) begin
                  word_ovf_ff <= 1'b1;
               end
               if (wrap_now) begin
                  pen_x_ff <= '0;
               end
            end
            ST_LINE: begin
               line_y_ff <= alu_sat;
            end
            ST_FLUSH_X: begin
               fx_ff <= alu_sat;
            end
            ST_FLUSH_Y: begin
               fy_ff <= alu_sat;
            end
            ST_FLUSH_ADV: begin
               pen_x_ff <= alu_sat;
            end
            ST_FLUSH_EMIT: begin
               if (out_free) begin
                  rsp_ff.glyph_number  <= ent.num;
                  rsp_ff.pos_x         <= fx_ff;
                  rsp_ff.pos_y         <= fy_ff;
                  rsp_ff.is_reposition <= 1'b1;
                  rsp_ff.word_overflow <= word_ovf_ff;
                  rsp_ff.last_of_run   <= 1'b0;
                  idx_ff               <= idx_next;
               end
            end
            ST_POS_X: begin
               px_ff <= alu_sat;
            end
            ST_POS_Y1: begin
               tmp_ff <= ALU_IN_BITS'(alu_raw);
            end
            ST_POS_Y2: begin
               py_ff <= alu_sat;
            end
            ST_PEN: begin
               pen_x_ff <= alu_sat;
               if (push_ff) begin
                  word_count_ff <= word_count_ff + WC_BITS'(1);
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff.glyph_number  <= num_ff;
                  rsp_ff.pos_x         <= px_ff;
                  rsp_ff.pos_y         <= py_ff;
                  rsp_ff.is_reposition <= 1'b0;
                  rsp_ff.word_overflow <= word_ovf_ff;
                  rsp_ff.last_of_run   <= 1'b1;
                  // end of text: return the layout state to its reset values
                  if (glyph_ff.is_final) begin
                     pen_x_ff         <= '0;
                     line_y_ff        <= '0;
                     glyph_counter_ff <= '0;
                     word_count_ff    <= '0;
                     word_ovf_ff      <= 1'b0;
                  end else begin
                     glyph_counter_ff <= glyph_counter_ff + GLYPH_INDEX_BITS'(1);
                     if (word_end_ff) begin
                        word_count_ff <= '0;
                        word_ovf_ff   <= 1'b0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph line wrap layout block.
// ----------------------------------------------------------------------------
// A table of directed glyph and register transactions runs first. Some rows
// carry their expected position typed in; the rest are checked against an
// in-bench layout predictor. Random word-shaped text follows under several
// register settings, with long runs that drive x and y into saturation. Both
// channels idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb;
   import gllw_pkg::*;

   localparam int WORD_DEPTH = (MAX_WORD_GLYPHS_DEF > BUF_DEPTH_LIMIT) ?
                               BUF_DEPTH_LIMIT : MAX_WORD_GLYPHS_DEF;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_AT_GLYPH  = 80;
   localparam int HOLD_CYCLES    = 400;
   localparam int PRINT_LIMIT    = 40;

   typedef enum logic {ROW_CFG, ROW_GLYPH} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type idx;
      logic [22:0]   val;
      req_type       glyph;
      logic          lit;
      rsp_type       want;
   } stim_row_type;

   localparam req_type NO_GLYPH  = '0;
   localparam rsp_type UNCHECKED = '0;

   localparam int DIRECTED_ROWS = 26;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // reset settings: no wrap, zero line height
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0000, 16'sh0000, 16'h0000, 1'b0, 1'b0},
        1'b1, '{12'd0, 24'sh000000, 24'sh000000, 1'b0, 1'b0, 1'b1}},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0, 1'b0},
        1'b1, '{12'd1, 24'sh007FFF, 24'sh008000, 1'b0, 1'b0, 1'b1}},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh8000, 16'sh7FFF, 16'h0000, 1'b0, 1'b1},
        1'b1, '{12'd2, 24'sh00FFFE, 24'shFF8001, 1'b0, 1'b0, 1'b1}},
      // character wrap at 12 px
      '{ROW_CFG, CSR_BREAK_MODE, 23'(BREAK_CHAR), NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_CFG, CSR_WRAP_WIDTH, 23'h000C00, NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_CFG, CSR_LINE_HEIGHT, 23'h001000, NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_CFG, CSR_LINE_SPACING, 23'h000200, NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0040, 16'sh0C00, 16'h0400, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0040, 16'sh0C00, 16'h0400, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0040, 16'sh0C00, 16'h0400, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0040, 16'sh0C00, 16'h0400, 1'b1, 1'b1},
        1'b0, UNCHECKED},
      // word wrap at 16 px: the space pushes the first word down
      '{ROW_CFG, CSR_BREAK_MODE, 23'(BREAK_WORD), NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_CFG, CSR_WRAP_WIDTH, 23'h001000, NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0000, 16'sh0A00, 16'h0500, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0000, 16'sh0A00, 16'h0500, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0000, 16'sh0A00, 16'h0500, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0000, 16'sh0000, 16'h0300, 1'b1, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0020, 16'sh0A00, 16'h0500, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0020, 16'sh0A00, 16'h0500, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      // leave the word buffered across a mode change, then flush it on the final glyph
      '{ROW_CFG, CSR_BREAK_MODE, 23'(BREAK_NONE), NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0000, 16'sh0A00, 16'h0100, 1'b0, 1'b0},
        1'b0, UNCHECKED},
      '{ROW_CFG, CSR_BREAK_MODE, 23'(BREAK_WORD), NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh0000, 16'sh0000, 16'h0100, 1'b0, 1'b1},
        1'b0, UNCHECKED},
      // unused mode never wraps, even at zero width
      '{ROW_CFG, CSR_BREAK_MODE, 23'(BREAK_UNUSED), NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_CFG, CSR_WRAP_WIDTH, 23'h000000, NO_GLYPH, 1'b0, UNCHECKED},
      '{ROW_GLYPH, CSR_BREAK_MODE, 23'd0, '{16'sh7FFF, 16'sh0000, 16'hFFFF, 1'b0, 1'b1},
        1'b1, '{12'd0, 24'sh007FFF, 24'sh001000, 1'b0, 1'b0, 1'b1}}
   };

   logic          clock;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   req_type       req_data    = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid   = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index   = CSR_BREAK_MODE;
   logic [22:0]   csr_data    = '0;

   // predictor copy of the registers and layout state
   break_mode_type     cfg_mode;
   logic [22:0]        cfg_wrap;
   logic [15:0]        cfg_height;
   logic [15:0]        cfg_spacing;
   logic signed [23:0] pen_x;
   logic signed [23:0] line_y;
   logic [11:0]        glyph_count;
   int                 held_count;
   bit                 word_ovf;
   entry_type          held [WORD_DEPTH];

   rsp_type pending_positions [$];

   int fail_count    = 0;
   int glyphs_taken  = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 37;
   int recv_idle_pct = 72;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   glyph_line_wrap_layout dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [23:0] clamp24(input longint v);
      if (v > longint'(S24_MAX)) return S24_MAX;
      if (v < longint'(S24_MIN)) return S24_MIN;
      return v[23:0];
   endfunction

   function automatic void clear_layout();
      pen_x       = '0;
      line_y      = '0;
      glyph_count = '0;
      held_count  = 0;
      word_ovf    = 1'b0;
   endfunction

   // Work out every position one glyph yields and queue them in order.
   function automatic void place_glyph(input req_type g);
      longint             line_step;
      longint             left;
      logic signed [23:0] x;
      logic signed [23:0] y;
      bit                 crosses;
      bit                 keep;
      bit                 ends;
      int                 i;
      rsp_type            r;
      line_step = longint'(cfg_height) + longint'(cfg_spacing);
      left      = longint'($signed(g.inset_left));
      crosses   = (cfg_wrap != WRAP_NO_LIMIT) &&
                  (longint'(pen_x) + left + longint'(g.advance) >= longint'(cfg_wrap));
      keep = 1'b0;
      ends = 1'b0;
      if (cfg_mode == BREAK_WORD) begin
         if (!g.is_space && !g.is_final) begin
            if (held_count < WORD_DEPTH) keep = 1'b1;
            else word_ovf = 1'b1;
         end else begin
            ends = 1'b1;
            if (crosses) begin
               pen_x  = '0;
               line_y = clamp24(longint'(line_y) + line_step);
               for (i = 0; i < held_count; i++) begin
                  x = clamp24(longint'(pen_x) + longint'($signed(held[i].left)));
                  y = clamp24(longint'($signed(held[i].y)) + line_step);
                  held[i].y = y;
                  r = '{held[i].num, x, y, 1'b1, word_ovf, 1'b0};
                  pending_positions.insert(pending_positions.size(), r);
                  pen_x = clamp24(longint'(x) + longint'(held[i].adv));
               end
            end
         end
      end else if (cfg_mode == BREAK_CHAR && crosses) begin
         pen_x  = '0;
         line_y = clamp24(longint'(line_y) + line_step);
      end
      x     = clamp24(longint'(pen_x) + left);
      y     = clamp24(longint'(cfg_height) - longint'($signed(g.inset_top)) +
                      longint'(line_y));
      pen_x = clamp24(longint'(x) + longint'(g.advance));
      if (keep) begin
         held[held_count] = '{glyph_count, g.inset_left, g.advance, y};
         held_count++;
      end
      r = '{glyph_count, x, y, 1'b0, word_ovf, 1'b1};
      pending_positions.insert(pending_positions.size(), r);
      if (ends) begin
         held_count = 0;
         word_ovf   = 1'b0;
      end
      glyph_count = glyph_count + 12'd1;
      if (g.is_final) clear_layout();
   endfunction

   task automatic note_mismatch(input string field, input logic [23:0] want,
                                input logic [23:0] got);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
   endtask

   task automatic check_position(input rsp_type got);
      rsp_type want;
      if (pending_positions.size() == 0) begin
         fail_count++;
         if (fail_count <= PRINT_LIMIT)
            $display("%0t: unexpected result, expected none, got %h", $time, got);
         return;
      end
      want = pending_positions.pop_front();
      if (got.glyph_number !== want.glyph_number)
         note_mismatch("glyph_number", 24'(want.glyph_number), 24'(got.glyph_number));
      if (got.pos_x !== want.pos_x)
         note_mismatch("pos_x", want.pos_x, got.pos_x);
      if (got.pos_y !== want.pos_y)
         note_mismatch("pos_y", want.pos_y, got.pos_y);
      if (got.is_reposition !== want.is_reposition)
         note_mismatch("is_reposition", 24'(want.is_reposition), 24'(got.is_reposition));
      if (got.word_overflow !== want.word_overflow)
         note_mismatch("word_overflow", 24'(want.word_overflow), 24'(got.word_overflow));
      if (got.last_of_run !== want.last_of_run)
         note_mismatch("last_of_run", 24'(want.last_of_run), 24'(got.last_of_run));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_position(rsp_data);
   end

   // Receiver: random stall, plus one long hold-off once enough glyphs are taken.
   always @(posedge clock) begin
      if (!hold_done && glyphs_taken >= HOLD_AT_GLYPH) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send_glyph(input req_type g);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= g;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      glyphs_taken++;
      place_glyph(g);
   endtask

   // Caller drops csr_valid once the last write of a group is done.
   task automatic write_csr(input csr_index_type idx, input logic [22:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BREAK_MODE:   cfg_mode    = break_mode_type'(val[1:0]);
         CSR_WRAP_WIDTH:   cfg_wrap    = val;
         CSR_LINE_HEIGHT:  cfg_height  = val[15:0];
         CSR_LINE_SPACING: cfg_spacing = val[15:0];
         default: ;
      endcase
   endtask

   // Hold input until every queued position is back and the block is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input break_mode_type m, input logic [22:0] w,
                                input logic [15:0] h, input logic [15:0] s);
      settle();
      write_csr(CSR_BREAK_MODE, 23'(m));
      write_csr(CSR_WRAP_WIDTH, w);
      write_csr(CSR_LINE_HEIGHT, 23'(h));
      write_csr(CSR_LINE_SPACING, 23'(s));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_glyph();
      req_type g;
      g.inset_left = ($urandom_range(4) == 0) ? 16'($urandom) :
                                                16'($urandom_range(255) - 64);
      g.inset_top  = 16'($urandom);
      g.advance    = ($urandom_range(4) == 0) ? 16'($urandom) :
                                                16'($urandom_range(2560, 128));
      g.is_space   = 1'b0;
      g.is_final   = 1'b0;
      return g;
   endfunction

   // Words of random glyphs ended by a space or a final glyph; some words
   // overflow the buffer, a few glyphs carry random flags.
   task automatic run_words(input int n);
      int      sent;
      int      len;
      int      k;
      req_type g;
      sent = 0;
      while (sent < n) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(36, 28) : $urandom_range(8, 1);
         for (k = 0; k < len; k++) begin
            g = random_glyph();
            if ($urandom_range(19) == 0) begin
               g.is_space = 1'($urandom);
               g.is_final = 1'($urandom);
            end
            send_glyph(g);
            sent++;
         end
         g          = random_glyph();
         g.is_space = ($urandom_range(6) != 0);
         g.is_final = !g.is_space || ($urandom_range(5) == 0);
         send_glyph(g);
         sent++;
      end
      // leave a word open across the next register change
      if ($urandom_range(1) == 1) begin
         len = $urandom_range(4, 1);
         for (k = 0; k < len; k++) send_glyph(random_glyph());
      end
   endtask

   task automatic run_sweep(input int n, input logic signed [15:0] left,
                            input logic [15:0] adv);
      int      k;
      req_type g;
      for (k = 0; k < n; k++) begin
         g = '{left, 16'($urandom), adv, 1'b0, k == n - 1};
         send_glyph(g);
      end
   endtask

   initial begin
      int             i;
      int             grp;
      int             p;
      break_mode_type m;
      logic [22:0]    w;
      logic [15:0]    h;
      logic [15:0]    s;

      cfg_mode    = BREAK_NONE;
      cfg_wrap    = WRAP_NO_LIMIT;
      cfg_height  = '0;
      cfg_spacing = '0;
      clear_layout();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_CFG) begin
            if (i == 0 || DIRECTED[i-1].kind != ROW_CFG) settle();
            write_csr(DIRECTED[i].idx, DIRECTED[i].val);
            if (i == DIRECTED_ROWS - 1 || DIRECTED[i+1].kind != ROW_CFG)
               csr_valid <= 1'b0;
         end else begin
            send_glyph(DIRECTED[i].glyph);
            // typed-in rows replace the predicted position
            if (DIRECTED[i].lit) begin
               void'(pending_positions.pop_back());
               pending_positions.insert(pending_positions.size(), DIRECTED[i].want);
            end
         end
      end

      for (grp = 0; grp < 3; grp++) begin
         send_idle_pct = (grp == 0) ? 37 : (grp == 1) ? 72 : 0;
         recv_idle_pct = (grp == 0) ? 72 : (grp == 1) ? 37 : 0;
         for (p = 0; p < 3; p++) begin
            case (p)
               0:       m = BREAK_WORD;
               1:       m = BREAK_CHAR;
               default: m = (grp == 1) ? BREAK_UNUSED : BREAK_WORD;
            endcase
            case ($urandom_range(5))
               0:       w = 23'd0;
               1:       w = WRAP_NO_LIMIT;
               2:       w = WRAP_NO_LIMIT - 23'd1;
               default: w = 23'($urandom_range(24576, 4096));
            endcase
            case ($urandom_range(3))
               0:       h = 16'h0000;
               1:       h = 16'hFFFF;
               default: h = 16'($urandom_range(8192, 2048));
            endcase
            case ($urandom_range(3))
               0:       s = 16'h0000;
               1:       s = 16'hFFFF;
               default: s = 16'($urandom_range(1024));
            endcase
            apply_setting(m, w, h, s);
            run_words(6);
         end
      end

      // drive y, then x upward into saturation
      apply_setting(BREAK_CHAR, 23'd0, 16'hFFFF, 16'hFFFF);
      run_sweep(70, 16'sh0000, 16'h0100);
      apply_setting(BREAK_NONE, WRAP_NO_LIMIT, 16'h0000, 16'h0000);
      run_sweep(90, 16'sh7FFF, 16'hFFFF);

      settle();
      if (fail_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
